>>> sv/srarq_pkg.sv
package srarq_pkg;

   // Command codes carried on req_tuser
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_ACK   = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Send kinds carried on rsp_tuser
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_NEW  = 2'd1;
   localparam logic [1:0] KIND_RETX = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [1:0] CSR_TOTAL_PACKETS = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // Reset values of the configuration registers
   localparam logic [6:0]  WINDOW_SIZE_RST   = 7'd8;
   localparam logic [31:0] TOTAL_PACKETS_RST = 32'd10000;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MARK,
      S_SLIDE,
      S_SEND,
      S_TICK_RD,
      S_TICK_WR,
      S_DONE
   } state_type;

endpackage

>>> sv/selective_repeat_arq_sender.sv
// Selective-repeat ARQ sender. Each accepted item is an event: start (send new
// sequence numbers while the window and the packet total allow), ack (mark an
// outstanding number acked, slide the base over acked numbers, then send new
// ones) or timer tick (count down every unacked outstanding slot; on expiry
// retransmit and reload). Each event yields one or more result items, one per
// transmission (new numbers rising, retransmissions from the base upward), or
// a single item with send_kind none; rsp_tlast marks the final item of the
// event, and window_base/all_done give the state after the event. A small
// sequencer walks the window one slot at a time and shares a single port pair
// on the countdown memory, so the block takes one event at a time; it also
// waits while the result side stalls. One result is held back a step so that
// the last flag is known when it is presented. Configuration registers are
// written through csr_we/csr_addr/csr_wdata and must only be changed while
// no event is in progress.
module selective_repeat_arq_sender #(
   parameter int WINDOW_MAX = 64,
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // event in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] ack_seq
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // results out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] send_seq, [63:32] window_base,
                                    // [64] all_done, [71:65] zero
   output logic [1:0]  rsp_tuser,   // [1:0] send_kind
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import srarq_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_MAX + 1);
   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SUM_W  = IDX_W + 1;
   localparam int CMP_W  = (IDX_W > 7) ? IDX_W : 7;
   localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);

   // configuration
   logic [6:0]  window_size_ff;
   logic [31:0] total_packets_ff;
   logic [15:0] timeout_ticks_ff;

   // sequencer and window state
   state_type         state_ff, state_in;
   logic [31:0]       ack_ff, ack_in;
   logic [31:0]       base_seq_ff, base_seq_in;
   logic [31:0]       next_seq_ff, next_seq_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [IDX_W-1:0]  span_ff, span_in;
   logic [WINDOW_MAX-1:0] acked_ff, acked_in;

   // tick scan position
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0] scan_slot_ff, scan_slot_in;
   logic [31:0]       scan_seq_ff, scan_seq_in;

   // held-back result
   logic        pend_valid_ff, pend_valid_in;
   logic [1:0]  pend_kind_ff, pend_kind_in;
   logic [31:0] pend_seq_ff, pend_seq_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_seq_ff, rsp_seq_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_base_ff, rsp_base_in;
   logic        rsp_done_ff, rsp_done_in;

   // countdown memory
   logic [TIMER_BITS-1:0] cd_mem [WINDOW_MAX];
   logic [TIMER_BITS-1:0] cd_rd_ff;
   logic                  cd_we;
   logic [SLOT_W-1:0]     cd_waddr;
   logic [TIMER_BITS-1:0] cd_wdata;
   logic                  cd_re;

   // shared helpers
   logic [32:0]           timeout_ext;
   logic [TIMER_BITS-1:0] reload;
   logic [CMP_W-1:0]      win_ext;
   logic [CMP_W-1:0]      eff_win;
   logic                  can_new;
   logic [31:0]           ack_off;
   logic [SUM_W-1:0]      ack_sum;
   logic [SLOT_W-1:0]     ack_slot;
   logic                  out_free;
   logic                  can_produce;
   logic                  all_done;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_done_ff, rsp_base_ff, rsp_seq_ff};

   // Saturate the reload value to the countdown width
   assign timeout_ext = 33'(timeout_ticks_ff);
   assign reload = (timeout_ext > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                             : timeout_ext[TIMER_BITS-1:0];

   // Clamp the window and test whether one more new number may go out
   assign win_ext = CMP_W'(window_size_ff);
   assign eff_win = (win_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : win_ext;
   assign can_new = (CMP_W'(span_ff) < eff_win) && (next_seq_ff < total_packets_ff);

   // Slot of the acked number: base slot plus offset, wrapped once
   assign ack_off  = ack_ff - base_seq_ff;
   assign ack_sum  = SUM_W'(base_slot_ff) + SUM_W'(ack_off[IDX_W-1:0]);
   assign ack_slot = (ack_sum >= SUM_W'(WINDOW_MAX)) ?
                     SLOT_W'(ack_sum - SUM_W'(WINDOW_MAX)) : SLOT_W'(ack_sum);

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign can_produce = !pend_valid_ff || out_free;
   assign all_done    = (base_seq_ff >= total_packets_ff);

   // Next state and datapath control
   always_comb begin
      logic       produce;
      logic [1:0] prod_kind;
      logic [31:0] prod_seq;
      logic       finish;

      produce   = 1'b0;
      prod_kind = KIND_NONE;
      prod_seq  = '0;
      finish    = 1'b0;

      state_in     = state_ff;
      ack_in       = ack_ff;
      base_seq_in  = base_seq_ff;
      next_seq_in  = next_seq_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      span_in      = span_ff;
      acked_in     = acked_ff;
      scan_idx_in  = scan_idx_ff;
      scan_slot_in = scan_slot_ff;
      scan_seq_in  = scan_seq_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_done_in  = rsp_done_ff;

      cd_we    = 1'b0;
      cd_waddr = next_slot_ff;
      cd_wdata = reload;
      cd_re    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ack_in       = req_tdata;
               scan_idx_in  = '0;
               scan_slot_in = base_slot_ff;
               scan_seq_in  = base_seq_ff;
               unique case (req_tuser)
                  CMD_START: state_in = S_SEND;
                  CMD_ACK:   state_in = S_MARK;
                  CMD_TICK:  state_in = S_TICK_RD;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_MARK: begin
            // mark only numbers that are outstanding
            if (ack_off < 32'(span_ff))
               acked_in[ack_slot] = 1'b1;
            state_in = S_SLIDE;
         end
         S_SLIDE: begin
            if ((span_ff != '0) && acked_ff[base_slot_ff]) begin
               acked_in[base_slot_ff] = 1'b0;
               base_seq_in  = base_seq_ff + 32'd1;
               base_slot_in = slot_inc(base_slot_ff);
               span_in      = span_ff - IDX_W'(1);
            end else begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (!can_new) begin
               state_in = S_DONE;
            end else if (can_produce) begin
               produce   = 1'b1;
               prod_kind = KIND_NEW;
               prod_seq  = next_seq_ff;
               acked_in[next_slot_ff] = 1'b0;
               cd_we        = 1'b1;
               cd_waddr     = next_slot_ff;
               cd_wdata     = reload;
               next_seq_in  = next_seq_ff + 32'd1;
               next_slot_in = slot_inc(next_slot_ff);
               span_in      = span_ff + IDX_W'(1);
            end
         end
         S_TICK_RD: begin
            if (scan_idx_ff >= span_ff) begin
               state_in = S_DONE;
            end else if (acked_ff[scan_slot_ff]) begin
               // acked slots hold their countdown
               scan_idx_in  = scan_idx_ff + IDX_W'(1);
               scan_slot_in = slot_inc(scan_slot_ff);
               scan_seq_in  = scan_seq_ff + 32'd1;
            end else begin
               cd_re    = 1'b1;
               state_in = S_TICK_WR;
            end
         end
         S_TICK_WR: begin
            cd_waddr = scan_slot_ff;
            if (cd_rd_ff > TIMER_BITS'(1)) begin
               cd_we    = 1'b1;
               cd_wdata = cd_rd_ff - TIMER_BITS'(1);
            end else if (can_produce) begin
               cd_we     = 1'b1;
               cd_wdata  = reload;
               produce   = 1'b1;
               prod_kind = KIND_RETX;
               prod_seq  = scan_seq_ff;
            end
            if (cd_we) begin
               scan_idx_in  = scan_idx_ff + IDX_W'(1);
               scan_slot_in = slot_inc(scan_slot_ff);
               scan_seq_in  = scan_seq_ff + 32'd1;
               state_in     = S_TICK_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Hand the held result to the output once a newer one exists
      if (produce) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = pend_kind_ff;
            rsp_seq_in   = pend_seq_ff;
            rsp_last_in  = 1'b0;
            rsp_base_in  = base_seq_ff;
            rsp_done_in  = all_done;
         end
         pend_valid_in = 1'b1;
         pend_kind_in  = prod_kind;
         pend_seq_in   = prod_seq;
      end

      // Close the event: the held result, or a status-only item, goes out last
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = pend_valid_ff ? pend_kind_ff : KIND_NONE;
         rsp_seq_in    = pend_valid_ff ? pend_seq_ff : 32'd0;
         rsp_last_in   = 1'b1;
         rsp_base_in   = base_seq_ff;
         rsp_done_in   = all_done;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_seq_ff   <= '0;
         next_seq_ff   <= '0;
         base_slot_ff  <= '0;
         next_slot_ff  <= '0;
         span_ff       <= '0;
         acked_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_seq_ff   <= base_seq_in;
         next_seq_ff   <= next_seq_in;
         base_slot_ff  <= base_slot_in;
         next_slot_ff  <= next_slot_in;
         span_ff       <= span_in;
         acked_ff      <= acked_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ack_ff       <= ack_in;
      scan_idx_ff  <= scan_idx_in;
      scan_slot_ff <= scan_slot_in;
      scan_seq_ff  <= scan_seq_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= WINDOW_SIZE_RST;
         total_packets_ff <= TOTAL_PACKETS_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WINDOW_SIZE:   window_size_ff   <= csr_wdata[6:0];
            CSR_TOTAL_PACKETS: total_packets_ff <= csr_wdata;
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Countdown memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cd_we)
         cd_mem[cd_waddr] <= cd_wdata;
      if (cd_re)
         cd_rd_ff <= cd_mem[scan_slot_ff];
   end

   // The outstanding count always matches the sequence numbers
   assert property (@(posedge clock) disable iff (reset)
      (next_seq_ff - base_seq_ff) == 32'(span_ff))
      else $error("outstanding count out of step with next_seq - base_seq");

   // Never more outstanding numbers than slots
   assert property (@(posedge clock) disable iff (reset)
      span_ff <= IDX_W'(WINDOW_MAX))
      else $error("outstanding count exceeds slot count");

   // No result may be held back between events
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held result left over at end of event");

   // Leaving the final state always presents a last item
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("event closed without a last item");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import srarq_pkg::*;

   // Command code outside the defined set; the block must treat it as a no-op
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam int WMAX        = 64;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] ack_seq
   logic [1:0]  req_tuser  = CMD_START;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;   // [31:0] send_seq, [63:32] window_base, [64] all_done, [71:65] zero
   logic [1:0]  rsp_tuser;   // [1:0] send_kind
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = CSR_WINDOW_SIZE;
   logic [31:0] csr_wdata  = '0;

   selective_repeat_arq_sender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // One transmission the sender is expected to report
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] seq;
      logic        last;
      logic [31:0] base;
      logic        done;
   } tx_type;

   // One line of the directed table: either a register write or an event.
   // Where typed is set, the expected burst is written out by hand: count
   // items of one kind with rising sequence numbers starting at seq0.
   typedef struct {
      bit          csr;
      logic [1:0]  code;
      logic [31:0] data;
      bit          typed;
      logic [1:0]  kind;
      logic [31:0] seq0;
      int          count;
      logic [31:0] base;
      bit          done;
   } row_type;

   // Sender model state and its copy of the registers
   logic [6:0]  cfg_window;
   logic [31:0] cfg_total;
   logic [15:0] cfg_timeout;
   logic [31:0] sr_base;
   logic [31:0] sr_next;
   bit          sr_acked [WMAX];
   logic [15:0] sr_count [WMAX];

   tx_type  step_out [$];   // burst of the event being predicted
   tx_type  tx_due [$];     // transmissions still owed by the block
   row_type plan [$];

   int  mismatches = 0;
   int  n_events   = 0;
   int  n_checked  = 0;
   int  n_retx     = 0;
   int  n_done     = 0;
   int  n_phases   = 0;
   int  cycles     = 0;
   bit  calm       = 1'b0;
   bit  csr_open   = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transmissions still owed",
                  cycles, tx_due.size());
         $display("[selective_repeat_arq_sender] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 20)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
      mismatches++;
   endtask

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   // Queue one transmission into the burst of the current event
   task automatic add_tx(input logic [1:0] kind, input logic [31:0] seq);
      tx_type t;
      if (step_out.size() >= WMAX)
         return;
      t.kind = kind;
      t.seq  = seq;
      t.last = 1'b0;
      t.base = '0;
      t.done = 1'b0;
      step_out.push_back(t);
   endtask

   // Send fresh numbers while the (clamped) window and the packet total allow
   task automatic send_fresh();
      logic [31:0] win;
      win = (cfg_window > WMAX) ? WMAX : cfg_window;
      while ((sr_next - sr_base) < win && sr_next < cfg_total) begin
         sr_acked[sr_next[5:0]] = 1'b0;
         sr_count[sr_next[5:0]] = cfg_timeout;
         add_tx(KIND_NEW, sr_next);
         sr_next++;
      end
   endtask

   // Advance the sender model by one event and build its burst in step_out
   task automatic sr_predict(input logic [1:0] cmd, input logic [31:0] ack);
      logic [31:0] span;
      logic [31:0] offs;
      logic [31:0] seq;
      step_out.delete();
      span = sr_next - sr_base;
      case (cmd)
         CMD_START: send_fresh();
         CMD_ACK: begin
            offs = ack - sr_base;
            // ignore acks below the base or at/above the next fresh number
            if (offs < span)
               sr_acked[ack[5:0]] = 1'b1;
            while (sr_base != sr_next && sr_acked[sr_base[5:0]]) begin
               sr_acked[sr_base[5:0]] = 1'b0;
               sr_base++;
            end
            send_fresh();
         end
         CMD_TICK: begin
            for (int i = 0; i < span && i < WMAX; i++) begin
               seq = sr_base + i;
               if (!sr_acked[seq[5:0]]) begin
                  if (sr_count[seq[5:0]] <= 16'd1) begin
                     add_tx(KIND_RETX, seq);
                     sr_count[seq[5:0]] = cfg_timeout;
                  end else begin
                     sr_count[seq[5:0]]--;
                  end
               end
            end
         end
         default: ;
      endcase
      if (step_out.size() == 0)
         add_tx(KIND_NONE, '0);
      foreach (step_out[k]) begin
         step_out[k].last = (k == step_out.size() - 1);
         step_out[k].base = sr_base;
         step_out[k].done = (sr_base >= cfg_total);
      end
   endtask

   // Hold valid until accepted, then predict and queue the burst
   task automatic put_event(input row_type r);
      int gap;
      tx_type t;
      gap = idle_draw();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.code;
      req_tdata  <= r.data;
      do @(posedge clock); while (!req_tready);
      sr_predict(r.code, r.data);
      if (r.typed) begin
         // the state still advances through the model; swap in the hand-written burst
         step_out.delete();
         for (int k = 0; k < r.count; k++) begin
            t.kind = r.kind;
            t.seq  = r.seq0 + k;
            t.last = (k == r.count - 1);
            t.base = r.base;
            t.done = r.done;
            step_out.push_back(t);
         end
      end
      foreach (step_out[k])
         tx_due.push_back(step_out[k]);
      n_events++;
   endtask

   // Drop valid and wait for every owed transmission, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tx_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write leaves the enable high so that back-to-back writes need no toggle
   task automatic csr_write(input logic [1:0] addr, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      csr_open   = 1'b1;
      @(posedge clock);
      case (addr)
         CSR_WINDOW_SIZE:   cfg_window  = value[6:0];
         CSR_TOTAL_PACKETS: cfg_total   = value;
         CSR_TIMEOUT_TICKS: cfg_timeout = value[15:0];
         default: ;
      endcase
   endtask

   task automatic csr_close();
      if (csr_open)
         csr_we <= 1'b0;
      csr_open = 1'b0;
   endtask

   task automatic plan_event(input logic [1:0] cmd, input logic [31:0] arg);
      row_type r;
      r = '{csr: 1'b0, code: cmd, data: arg, typed: 1'b0, kind: KIND_NONE,
            seq0: '0, count: 0, base: '0, done: 1'b0};
      plan.push_back(r);
   endtask

   task automatic plan_typed(input logic [1:0] cmd, input logic [31:0] arg,
                             input logic [1:0] kind, input logic [31:0] seq0,
                             input int count, input logic [31:0] base, input bit done);
      row_type r;
      r = '{csr: 1'b0, code: cmd, data: arg, typed: 1'b1, kind: kind,
            seq0: seq0, count: count, base: base, done: done};
      plan.push_back(r);
   endtask

   task automatic plan_csr(input logic [1:0] addr, input logic [31:0] value);
      row_type r;
      r = '{csr: 1'b1, code: addr, data: value, typed: 1'b0, kind: KIND_NONE,
            seq0: '0, count: 0, base: '0, done: 1'b0};
      plan.push_back(r);
   endtask

   // Pick one event from the current model state: mostly acks of numbers
   // in flight and ticks, with some starts and a share of noise.
   task automatic random_event();
      row_type     r;
      logic [31:0] span;
      int          pick;
      span = sr_next - sr_base;
      pick = $urandom_range(0, 99);
      r = '{csr: 1'b0, code: CMD_TICK, data: $urandom(), typed: 1'b0, kind: KIND_NONE,
            seq0: '0, count: 0, base: '0, done: 1'b0};
      if (pick < 50 && span == 0)
         r.code = CMD_START;
      else if (pick < 35) begin
         r.code = CMD_ACK;
         r.data = sr_base + $urandom_range(0, span - 1);
      end else if (pick < 50) begin
         r.code = CMD_ACK;
         r.data = sr_base;
      end else if (pick < 70)
         r.code = CMD_TICK;
      else if (pick < 80)
         r.code = CMD_START;
      else if (pick < 88) begin
         // just outside the window on either side
         r.code = CMD_ACK;
         r.data = $urandom_range(0, 1) ? sr_base - $urandom_range(1, 4)
                                        : sr_next + $urandom_range(0, 3);
      end else if (pick < 95)
         r.code = CMD_ACK;
      else
         r.code = CMD_UNKNOWN;
      put_event(r);
   endtask

   // Result side: stall a random number of cycles before each item
   initial begin
      int stall;
      while (reset)
         @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted result with the oldest owed transmission
   always @(posedge clock) begin
      tx_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tx_due.size() == 0) begin
            report_mismatch("result with nothing owed, send_seq", rsp_tdata[31:0], '0);
         end else begin
            want = tx_due.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("send_kind", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[31:0] !== want.seq)
               report_mismatch("send_seq", rsp_tdata[31:0], want.seq);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            if (rsp_tdata[63:32] !== want.base)
               report_mismatch("window_base", rsp_tdata[63:32], want.base);
            if (rsp_tdata[64] !== want.done)
               report_mismatch("all_done", 32'(rsp_tdata[64]), 32'(want.done));
            if (rsp_tdata[71:65] !== 7'd0)
               report_mismatch("tdata padding", 32'(rsp_tdata[71:65]), '0);
            n_checked++;
            if (want.kind == KIND_RETX)
               n_retx++;
            if (want.done)
               n_done++;
         end
      end
   end

   initial begin
      int n_directed;

      // model state after reset
      cfg_window  = WINDOW_SIZE_RST;
      cfg_total   = TOTAL_PACKETS_RST;
      cfg_timeout = TIMEOUT_TICKS_RST;
      sr_base     = '0;
      sr_next     = '0;
      for (int i = 0; i < WMAX; i++) begin
         sr_acked[i] = 1'b0;
         sr_count[i] = '0;
      end

      // Directed table, starting from the reset settings (window 8, timeout 100)
      plan_typed(CMD_TICK,    32'h0,        KIND_NONE, 0, 1, 0, 0);   // nothing in flight
      plan_typed(CMD_UNKNOWN, 32'h0,        KIND_NONE, 0, 1, 0, 0);
      plan_typed(CMD_START,   32'h0,        KIND_NEW,  0, 8, 0, 0);
      plan_typed(CMD_START,   32'hFFFFFFFF, KIND_NONE, 0, 1, 0, 0);   // window full
      plan_typed(CMD_ACK,     32'hFFFFFFFF, KIND_NONE, 0, 1, 0, 0);   // far outside window
      plan_typed(CMD_ACK,     32'd8,        KIND_NONE, 0, 1, 0, 0);   // at next, not in flight
      plan_typed(CMD_ACK,     32'd3,        KIND_NONE, 0, 1, 0, 0);   // hole, base holds
      plan_typed(CMD_ACK,     32'd3,        KIND_NONE, 0, 1, 0, 0);   // repeated ack
      plan_typed(CMD_ACK,     32'd0,        KIND_NEW,  8, 1, 1, 0);
      plan_event(CMD_TICK,    32'h0);
      plan_csr(CSR_TIMEOUT_TICKS, 32'd1);
      plan_event(CMD_ACK,     32'd1);
      plan_event(CMD_TICK,    32'h0);   // short timeout expires at once
      plan_event(CMD_TICK,    32'h0);
      plan_csr(CSR_WINDOW_SIZE, 32'd0);
      plan_event(CMD_ACK,     32'd2);   // slides over the earlier hole
      plan_typed(CMD_START,   32'h0,        KIND_NONE, 0, 1, 4, 0);   // window zero
      plan_csr(CSR_WINDOW_SIZE, 32'd127);
      plan_csr(CSR_TOTAL_PACKETS, 32'd20);
      plan_event(CMD_START,   32'h0);   // clamps to the full window, stops at total
      plan_csr(CSR_WINDOW_SIZE, 32'd2);
      plan_typed(CMD_START,   32'h0,        KIND_NONE, 0, 1, 4, 0);   // shrunk window
      plan_csr(CSR_TOTAL_PACKETS, 32'd5);
      plan_event(CMD_TICK,    32'h0);   // lowered total, still retransmits
      plan_typed(CMD_ACK,     32'd4,        KIND_NONE, 0, 1, 5, 1);   // base reaches total
      plan_typed(CMD_ACK,     32'd0,        KIND_NONE, 0, 1, 5, 1);   // below base
      plan_event(CMD_TICK,    32'hFFFFFFFF);
      plan_csr(CSR_TIMEOUT_TICKS, 32'd0);
      plan_event(CMD_TICK,    32'h0);   // timeout zero

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table; register writes only once the block is idle
      foreach (plan[i]) begin
         if (plan[i].csr) begin
            if (!csr_open)
               drain();
            csr_write(plan[i].code, plan[i].data);
         end else begin
            csr_close();
            put_event(plan[i]);
         end
      end
      n_directed = n_events;

      // Random phases, each with its own settings, extremes first
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain();
         case (p)
            0: begin
               csr_write(CSR_WINDOW_SIZE,   32'd64);
               csr_write(CSR_TOTAL_PACKETS, 32'hFFFFFFFF);
               csr_write(CSR_TIMEOUT_TICKS, 32'd1);
            end
            1: begin
               csr_write(CSR_WINDOW_SIZE,   32'd127);
               csr_write(CSR_TOTAL_PACKETS, sr_next + $urandom_range(20, 60));
               csr_write(CSR_TIMEOUT_TICKS, 32'd2);
            end
            2: begin
               csr_write(CSR_WINDOW_SIZE,   32'd1);
               csr_write(CSR_TOTAL_PACKETS, 32'hFFFFFFFF);
               csr_write(CSR_TIMEOUT_TICKS, 32'd65535);
            end
            3: begin
               csr_write(CSR_WINDOW_SIZE,   32'd0);
               csr_write(CSR_TIMEOUT_TICKS, 32'd0);
            end
            4: begin
               csr_write(CSR_WINDOW_SIZE,   $urandom_range(2, 16));
               csr_write(CSR_TOTAL_PACKETS, 32'd0);
               csr_write(CSR_TIMEOUT_TICKS, $urandom_range(1, 6));
            end
            5: begin
               csr_write(CSR_WINDOW_SIZE,   $urandom_range(1, 127));
               csr_write(CSR_TOTAL_PACKETS, sr_next + $urandom_range(0, 40));
               csr_write(CSR_TIMEOUT_TICKS, $urandom_range(1, 8));
            end
            6: begin
               csr_write(CSR_WINDOW_SIZE,   32'd8);
               csr_write(CSR_TOTAL_PACKETS, sr_next + $urandom_range(5, 30));
               csr_write(CSR_TIMEOUT_TICKS, $urandom_range(2, 20));
            end
            default: begin
               // total may land below numbers already in flight
               csr_write(CSR_WINDOW_SIZE,   $urandom_range(0, 127));
               csr_write(CSR_TOTAL_PACKETS, sr_base + $urandom_range(0, 12));
               csr_write(CSR_TIMEOUT_TICKS, 32'd1);
            end
         endcase
         csr_close();
         n_phases++;
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_event();
      end

      calm = 1'b0;
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d events (%0d directed) over %0d random settings, final base %0d",
               n_events, n_directed, n_phases, sr_base);
      $display("checked %0d results: %0d retransmissions, %0d with all_done, %0d mismatches",
               n_checked, n_retx, n_done, mismatches);
      if (mismatches == 0 && tx_due.size() == 0) begin
         $display("[selective_repeat_arq_sender] OK");
      end else begin
         $display("[selective_repeat_arq_sender] ERROR");
      end
      $finish;
   end

endmodule
